[sv/ps2_mouse_packet_tracker_defines.svh]
// Assertion macros for the checker file of the PS/2 mouse packet tracker.
// No dependencies.
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PS2MPT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PS2MPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/ps2mpt_pkg.sv]
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies; imported by every module of the block.
package ps2mpt_pkg;

   localparam int unsigned POS_W      = 16;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [POS_W-1:0]  DEFAULT_MAX    = 16'd1000;
   localparam logic [POS_W-1:0]  START_POS      = 16'd500;
   localparam logic [BYTE_W-1:0] START_BIT_MASK = 8'h08;

   // Register index codes, taken from paddr bit 2.
   localparam logic REG_MAX_HORIZONTAL = 1'b0;
   localparam logic REG_MAX_VERTICAL   = 1'b1;

   typedef struct packed {
      logic              from_aux_port;
      logic [BYTE_W-1:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [POS_W-1:0] max_horizontal;
      logic [POS_W-1:0] max_vertical;
   } limits_type;

endpackage

[sv/ps2_mouse_packet_tracker.sv]
// PS/2 mouse packet tracker: takes one controller byte per transaction, aligns
// three-byte mouse packets (first byte with bit 3 set, then X, then Y), adds X
// and subtracts Y from a position held inside the block, clamps each axis to
// 0..its limit register, and sends the new position when a packet completes.
// Bytes not flagged as coming from the mouse port are dropped. The block takes
// one byte every cycle while no Y byte is held back; a result appears on rsp
// when the tracking stage moves the Y byte of a packet from the input register
// into the result register. While an earlier position still waits on rsp, a Y
// byte stays in the input register and req_tready follows rsp_tready. Limits
// reset to 1000 and the position to 500 on each axis. Depends on ps2mpt_pkg and
// its submodules.
module ps2_mouse_packet_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] rx_byte
   input  logic                                req_tuser,  // [0] from_aux_port
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,  // [15:0] pos_horizontal, [31:16] pos_vertical
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ps2mpt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ps2mpt_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ps2mpt_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import ps2mpt_pkg::*;

   req_item_type req_item;
   req_item_type item;
   logic         item_valid;
   logic         item_take;
   limits_type   limits;

   assign req_item.from_aux_port = req_tuser;
   assign req_item.rx_byte       = req_tdata;

   ps2mpt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .limits      (limits)
   );

   ps2mpt_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   ps2mpt_track u_track (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .limits     (limits),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[sv/ps2mpt_csr.sv]
// Configuration registers of the PS/2 mouse packet tracker (clamp limits).
// Depends on ps2mpt_pkg.
module ps2mpt_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [ps2mpt_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [ps2mpt_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [ps2mpt_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                    csr_pready,
   output ps2mpt_pkg::limits_type                  limits
);
   import ps2mpt_pkg::*;

   limits_type limits_ff;
   limits_type limits_in;
   logic       wr_en;
   logic       reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      limits_in = limits_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_MAX_HORIZONTAL: limits_in.max_horizontal = csr_pwdata[POS_W-1:0];
            REG_MAX_VERTICAL:   limits_in.max_vertical   = csr_pwdata[POS_W-1:0];
            default:            limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.max_horizontal <= DEFAULT_MAX;
         limits_ff.max_vertical   <= DEFAULT_MAX;
      end else begin
         limits_ff <= limits_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MAX_HORIZONTAL: csr_prdata = {{(CSR_DATA_W-POS_W){1'b0}}, limits_ff.max_horizontal};
         REG_MAX_VERTICAL:   csr_prdata = {{(CSR_DATA_W-POS_W){1'b0}}, limits_ff.max_vertical};
         default:            csr_prdata = '0;
      endcase
   end

   assign limits = limits_ff;

endmodule

[sv/ps2mpt_in_stage.sv]
// Input register of the PS/2 mouse packet tracker: holds one received byte
// until the tracking stage takes it. Depends on ps2mpt_pkg.
module ps2mpt_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  ps2mpt_pkg::req_item_type  req_item,
   output logic                      item_valid,
   output ps2mpt_pkg::req_item_type  item,
   input  logic                      item_take
);
   import ps2mpt_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   req_item_type item_in;

   // The register refills in the same cycle that the tracker drains it.
   assign req_tready = !valid_ff || item_take;

   always_comb begin
      valid_in = req_tready ? req_tvalid : valid_ff;
      item_in  = (req_tvalid && req_tready) ? req_item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[sv/ps2mpt_track.sv]
// Packet alignment, position update with clamping, and the result register.
// Depends on ps2mpt_pkg.
module ps2mpt_track (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   input  ps2mpt_pkg::req_item_type     item,
   output logic                         item_take,
   input  ps2mpt_pkg::limits_type       limits,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [2*ps2mpt_pkg::POS_W-1:0] rsp_tdata
);
   import ps2mpt_pkg::*;

   localparam logic [1:0] PHASE_WAIT_FIRST = 2'd0;
   localparam logic [1:0] PHASE_WAIT_X     = 2'd1;
   localparam logic [1:0] PHASE_WAIT_Y     = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] held_dx_ff, held_dx_in;
   logic [POS_W-1:0]  cur_h_ff, cur_h_in;
   logic [POS_W-1:0]  cur_v_ff, cur_v_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_h_ff, rsp_h_in;
   logic [POS_W-1:0]  rsp_v_ff, rsp_v_in;

   logic              completes;
   logic              out_free;
   logic signed [8:0] dx;
   logic signed [8:0] neg_dy;
   logic [POS_W-1:0]  new_h;
   logic [POS_W-1:0]  new_v;

   function automatic logic [POS_W-1:0] clamp_add(input logic [POS_W-1:0] pos,
                                                  input logic signed [8:0] delta,
                                                  input logic [POS_W-1:0] limit);
      logic signed [POS_W+1:0] sum;
      logic [POS_W-1:0]        res;
      sum = $signed({2'b00, pos}) + $signed({{(POS_W-7){delta[8]}}, delta});
      if (sum < 0) begin
         res = '0;
      end else if (sum > $signed({2'b00, limit})) begin
         res = limit;
      end else begin
         res = sum[POS_W-1:0];
      end
      return res;
   endfunction

   // Only the Y byte of a packet needs a free result register.
   assign completes = item.from_aux_port && (phase_ff == PHASE_WAIT_Y);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign item_take = item_valid && (!completes || out_free);

   assign dx     = $signed({held_dx_ff[BYTE_W-1], held_dx_ff});
   assign neg_dy = 9'sd0 - $signed({item.rx_byte[BYTE_W-1], item.rx_byte});
   assign new_h  = clamp_add(cur_h_ff, dx, limits.max_horizontal);
   assign new_v  = clamp_add(cur_v_ff, neg_dy, limits.max_vertical);

   always_comb begin
      phase_in   = phase_ff;
      held_dx_in = held_dx_ff;
      cur_h_in   = cur_h_ff;
      cur_v_in   = cur_v_ff;
      if (item_take && item.from_aux_port) begin
         case (phase_ff)
            PHASE_WAIT_X: begin
               held_dx_in = item.rx_byte;
               phase_in   = PHASE_WAIT_Y;
            end
            PHASE_WAIT_Y: begin
               phase_in = PHASE_WAIT_FIRST;
               cur_h_in = new_h;
               cur_v_in = new_v;
            end
            default: begin
               // A first byte must carry the always-one bit, otherwise it is dropped.
               phase_in = ((item.rx_byte & START_BIT_MASK) != '0) ? PHASE_WAIT_X
                                                                 : PHASE_WAIT_FIRST;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_v_in     = rsp_v_ff;
      if (item_take && completes) begin
         rsp_valid_in = 1'b1;
         rsp_h_in     = new_h;
         rsp_v_in     = new_v;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_WAIT_FIRST;
         cur_h_ff     <= START_POS;
         cur_v_ff     <= START_POS;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cur_h_ff     <= cur_h_in;
         cur_v_ff     <= cur_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_dx_ff <= held_dx_in;
      rsp_h_ff   <= rsp_h_in;
      rsp_v_ff   <= rsp_v_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_v_ff, rsp_h_ff};

endmodule

[sv/ps2mpt_checker.sv]
// Port-level checker for the PS/2 mouse packet tracker, bound to the top level.
// Depends on ps2_mouse_packet_tracker_defines.svh and ps2mpt_pkg.
`include "ps2_mouse_packet_tracker_defines.svh"

module ps2mpt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [31:0]                         rsp_tdata,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [ps2mpt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input logic [ps2mpt_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input logic [ps2mpt_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input logic                                csr_pready
);
   import ps2mpt_pkg::*;

   logic csr_wr;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   `PS2MPT_ASSERT_NEXT(a_rsp_valid_hold, clock, reset,
      rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp_tvalid dropped while stalled")

   `PS2MPT_ASSERT_NEXT(a_rsp_data_hold, clock, reset,
      rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp_tdata changed while stalled")

   `PS2MPT_ASSERT_IMPLY(a_reset_clears_rsp, clock, reset,
      $past(reset), !rsp_tvalid, "result pending right after reset")

   `PS2MPT_ASSERT_NEXT(a_max_h_readback, clock, reset,
      csr_wr && (csr_paddr[2] == REG_MAX_HORIZONTAL),
      (csr_paddr[2] != REG_MAX_HORIZONTAL) ||
         (csr_prdata[POS_W-1:0] == $past(csr_pwdata[POS_W-1:0])),
      "horizontal limit readback mismatch")

   `PS2MPT_ASSERT_NEXT(a_max_v_readback, clock, reset,
      csr_wr && (csr_paddr[2] == REG_MAX_VERTICAL),
      (csr_paddr[2] != REG_MAX_VERTICAL) ||
         (csr_prdata[POS_W-1:0] == $past(csr_pwdata[POS_W-1:0])),
      "vertical limit readback mismatch")

endmodule

bind ps2_mouse_packet_tracker ps2mpt_checker u_checker (.*);

[tb/ps2_mouse_packet_tracker_tb.sv]
// Self-checking testbench for the PS/2 mouse packet tracker: drives mouse and
// non-mouse bytes, predicts each completed packet's clamped position in a scoreboard.
// Depends on ps2mpt_pkg and ps2_mouse_packet_tracker.
`timescale 1ns / 100ps

module ps2_mouse_packet_tracker_tb;
   import ps2mpt_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int NUM_PHASES    = 6;
   localparam int RANDOM_BYTES  = 126;

   typedef enum logic [1:0] {
      WAIT_HEAD,
      WAIT_DX,
      WAIT_DY
   } packet_phase_type;

   // Same layout as rsp_tdata: horizontal in the low half.
   typedef struct packed {
      logic [POS_W-1:0] pos_vertical;
      logic [POS_W-1:0] pos_horizontal;
   } position_type;

   class pointer_tracker_sb;
      packet_phase_type phase;
      logic [7:0]       held_dx;
      logic [POS_W-1:0] cur_h;
      logic [POS_W-1:0] cur_v;
      logic [POS_W-1:0] max_h;
      logic [POS_W-1:0] max_v;
      position_type     pending_positions[$];
      int unsigned      failures;

      function new();
         phase    = WAIT_HEAD;
         held_dx  = '0;
         cur_h    = START_POS;
         cur_v    = START_POS;
         max_h    = DEFAULT_MAX;
         max_v    = DEFAULT_MAX;
         failures = 0;
      endfunction

      function logic [POS_W-1:0] clamp_move(logic [POS_W-1:0] pos, int delta,
                                            logic [POS_W-1:0] limit);
         int v;
         v = int'(pos) + delta;
         if (v < 0) v = 0;
         if (v > int'(limit)) v = int'(limit);
         return v[POS_W-1:0];
      endfunction

      function void set_limit(logic reg_sel, logic [POS_W-1:0] value);
         if (reg_sel == REG_MAX_HORIZONTAL) max_h = value;
         else max_v = value;
      endfunction

      function void note_byte(bit aux, logic [7:0] value);
         int dx;
         int dy;
         position_type p;
         if (!aux) return;
         case (phase)
            WAIT_DX: begin
               held_dx = value;
               phase   = WAIT_DY;
            end
            WAIT_DY: begin
               dx = $signed(held_dx);
               dy = $signed(value);
               phase = WAIT_HEAD;
               // Screen Y grows downward, so the mouse Y delta is subtracted.
               cur_h = clamp_move(cur_h, dx, max_h);
               cur_v = clamp_move(cur_v, -dy, max_v);
               p.pos_horizontal = cur_h;
               p.pos_vertical   = cur_v;
               pending_positions.push_back(p);
            end
            default: begin
               phase = ((value & START_BIT_MASK) != 0) ? WAIT_DX : WAIT_HEAD;
            end
         endcase
      endfunction

      function void check_position(position_type got);
         position_type want;
         if (pending_positions.size() == 0) begin
            $error("position result with none outstanding: h=%0d v=%0d",
                   got.pos_horizontal, got.pos_vertical);
            failures++;
            return;
         end
         want = pending_positions.pop_front();
         if (got.pos_horizontal !== want.pos_horizontal) begin
            $error("pos_horizontal: expected %0d, actual %0d",
                   want.pos_horizontal, got.pos_horizontal);
            failures++;
         end
         if (got.pos_vertical !== want.pos_vertical) begin
            $error("pos_vertical: expected %0d, actual %0d",
                   want.pos_vertical, got.pos_vertical);
            failures++;
         end
      endfunction

      function int pending();
         return pending_positions.size();
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;   // [7:0] rx_byte
   logic req_tuser = 1'b0;       // [0] from_aux_port
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // [15:0] pos_horizontal, [31:16] pos_vertical
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   pointer_tracker_sb sb = new();

   ps2_mouse_packet_tracker uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("ps2_mouse_packet_tracker verification failed");
      $finish;
   end

   // Result monitor; also throttles the result side.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_position(position_type'(rsp_tdata));
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_byte(input bit aux, input logic [7:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= aux;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(aux, value);
   endtask

   task automatic send_packet(input logic [7:0] head, input logic [7:0] dx,
                              input logic [7:0] dy);
      send_byte(1'b1, head);
      send_byte(1'b1, dx);
      send_byte(1'b1, dy);
   endtask

   // Holds the sender off until every outstanding position has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_sel, input logic [POS_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({reg_sel, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_limit(reg_sel, value);
   endtask

   // Mostly well-formed packets with random deltas, plus stray and non-mouse bytes.
   task automatic random_traffic(input int num_bytes);
      int sent;
      int pick;
      logic [7:0] head;
      sent = 0;
      while (sent < num_bytes) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_byte(1'b0, 8'($urandom));
         end else if (pick < 16) begin
            send_byte(1'b1, 8'($urandom));
            sent++;
         end else begin
            head = 8'($urandom) | START_BIT_MASK;
            send_byte(1'b1, head);
            if ($urandom_range(9) == 0) send_byte(1'b0, 8'($urandom));
            send_byte(1'b1, 8'($urandom));
            if ($urandom_range(9) == 0) send_byte(1'b0, 8'($urandom));
            send_byte(1'b1, 8'($urandom));
            sent += 3;
         end
      end
   endtask

   logic [POS_W-1:0] limit_h [NUM_PHASES] = '{16'd1000, 16'd0, 16'd65535,
                                               16'd100, 16'd65535, 16'd1000};
   logic [POS_W-1:0] limit_v [NUM_PHASES] = '{16'd1000, 16'd65535, 16'd0,
                                               16'd3000, 16'd65535, 16'd200};

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p < 2) begin
            send_idle_pct = 26;
            recv_idle_pct = 48;
         end else if (p < 4) begin
            send_idle_pct = 48;
            recv_idle_pct = 26;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         if (p == 0) begin
            // A header from the keyboard port must not start a packet.
            send_byte(1'b0, 8'h08);
            // Headers with bit 3 clear are dropped while waiting for a packet.
            send_byte(1'b1, 8'h00);
            send_byte(1'b1, 8'hF7);
            send_packet(8'h08, 8'h7F, 8'h80);
            // Non-mouse bytes between the bytes of one packet.
            send_byte(1'b1, 8'hFF);
            send_byte(1'b0, 8'h55);
            send_byte(1'b1, 8'h80);
            send_byte(1'b0, 8'hAA);
            send_byte(1'b1, 8'h7F);
            send_packet(8'h08, 8'h00, 8'h00);
            // Sign and overflow bits set in the header; moves both axes down.
            repeat (4) send_packet(8'hF8, 8'h80, 8'h7F);
         end else begin
            // Limits may drop below the current position; it clamps on the next packet.
            drain();
            csr_write(REG_MAX_HORIZONTAL, limit_h[p]);
            csr_write(REG_MAX_VERTICAL, limit_v[p]);
         end
         random_traffic(RANDOM_BYTES);
      end

      drain();
      if (sb.failures == 0) begin
         $display("ps2_mouse_packet_tracker verification clean");
      end else begin
         $display("ps2_mouse_packet_tracker verification failed");
      end
      $finish;
   end

endmodule

[ps2_mouse_packet_tracker.f]
+incdir+sv
sv/ps2mpt_pkg.sv
sv/ps2mpt_csr.sv
sv/ps2mpt_in_stage.sv
sv/ps2mpt_track.sv
sv/ps2_mouse_packet_tracker.sv
sv/ps2mpt_checker.sv
tb/ps2_mouse_packet_tracker_tb.sv
